// File: hw/rtl/ttcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants of the text terminal cell writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // port widths
  localparam int CHAR_W   = 8;
  localparam int PROW_W   = 5;
  localparam int PCOL_W   = 7;
  localparam int PDIRTY_W = 5;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

// File: hw/rtl/text_terminal_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// Character-cell terminal store with cursor, scrolling and dirty-row ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers (in_*) carry a write or a read request; each one gives
//   exactly one result transfer on out_*. Both channels use valid/stall.
//   A write is finished in the cycle it is taken: its result is registered
//   and shows in the next cycle, and the next item can be taken right away,
//   so writes run at one item per cycle, scrolls included, while out_stall
//   is low. A read passes the RAM output registers and then ST_READ: the
//   cell RAM and the row-fill RAM are read at the transfer edge and the
//   character is registered in the cycle after, in ST_READ, which takes no item.
//   The grid is a ring of physical rows with a top-row pointer; a scroll
//   moves the pointer. Each row keeps how many leading cells were written
//   since it last became blank, cells beyond that read as space, so reset
//   and scrolling need no sweep over the store.
//   Reset (rst_n low, synchronous) puts the cursor at 0,0, empties the span
//   range and blanks the grid at once; items are taken on the next cycle.
//   While out_stall is high the result holds and a new item is taken only
//   in the cycle the waiting result is transferred.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer
  import ttcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic                in_end_of_span,
  input  logic [PROW_W-1:0]   in_read_row,
  input  logic [PCOL_W-1:0]   in_read_col,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PDIRTY_W-1:0] out_dirty_begin,
  output logic [PDIRTY_W-1:0] out_dirty_end,
  output logic [PDIRTY_W-1:0] out_span_begin_out,
  output logic [PDIRTY_W-1:0] out_span_end_out,
  output logic                out_scrolled,
  output logic [CHAR_W-1:0]   out_read_char,
  output logic [PCOL_W-1:0]   out_cursor_col_out,
  output logic [PROW_W-1:0]   out_cursor_row_out
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int RCW = $clog2(ROWS + 1);
  localparam int FW  = $clog2(COLUMNS + 1);
  localparam int CELL_DEPTH = ROWS * (2 ** CW);

  // ring position of a logical row
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                             input logic [RW-1:0] lrow);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, lrow};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [RW-1:0]  base_r, base_nxt;
  logic [RCW-1:0] span_b_r, span_b_nxt;
  logic [RCW-1:0] span_e_r, span_e_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [RCW-1:0] o_db_r, o_de_r, o_sb_r, o_se_r;
  logic           o_scr_r;
  logic [CHAR_W-1:0] o_char_r;
  logic [CW-1:0]  o_col_r;
  logic [RW-1:0]  o_row_r;

  // read request held over the RAM latency
  logic          rd_oor_r, rd_above_r, rd_cur_r;
  logic [CW-1:0] rd_col_r;

  logic          accept, acc_wr, acc_rd;
  logic          is_nl, wraps, adv, scr;
  logic [RW-1:0] cur_phys;
  logic [RCW-1:0] db, de, mb, me;
  logic          rd_in_range;
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;

  logic                    cell_we;
  logic [RW+CW-1:0]        cell_waddr, cell_raddr;
  logic [CHAR_W-1:0]       cell_q;
  logic                    fill_we;
  logic [FW-1:0]           fill_wdata, fill_q;
  logic [CHAR_W-1:0]       rd_char;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_rd) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = out_valid_r && out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign acc_wr = accept && (mode_t'(in_mode) == MODE_WRITE);
  assign acc_rd = accept && (mode_t'(in_mode) == MODE_READ);

  // ---------------- write datapath ----------------
  assign cur_phys = phys_row(base_r, cur_row_r);
  assign is_nl    = (in_char_code == NEWLINE_CODE);
  assign wraps    = !is_nl && (cur_col_r == CW'(COLUMNS - 1));
  assign adv      = is_nl || wraps;
  assign scr      = adv && (cur_row_r == RW'(ROWS - 1));

  always_comb begin
    if (scr) begin
      db = '0;
      de = RCW'(ROWS);
    end else if (adv) begin
      db = RCW'(cur_row_r);
      de = RCW'(cur_row_r) + RCW'(2);
    end else begin
      db = RCW'(cur_row_r);
      de = RCW'(cur_row_r) + RCW'(1);
    end
  end

  // span union after merging this write's range
  always_comb begin
    mb = span_b_r;
    me = span_e_r;
    if (span_b_r == span_e_r) begin
      mb = db;
      me = de;
    end else begin
      if (db < span_b_r) mb = db;
      if (de > span_e_r) me = de;
    end
  end

  assign cell_we    = acc_wr && !is_nl;
  assign cell_waddr = {cur_phys, cur_col_r};
  // the row being left records how many leading cells it holds
  assign fill_we    = acc_wr && adv;
  assign fill_wdata = is_nl ? FW'(cur_col_r) : FW'(COLUMNS);

  // ---------------- read datapath ----------------
  assign rd_in_range = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);
  assign rd_row      = RW'(in_read_row);
  assign rd_col      = CW'(in_read_col);
  assign cell_raddr  = {phys_row(base_r, rd_row), rd_col};

  ttcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (in_char_code),
    .re    (acc_rd),
    .raddr (cell_raddr),
    .rdata (cell_q)
  );

  ttcw_ram #(
    .WIDTH (FW),
    .DEPTH (ROWS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (cur_phys),
    .wdata (fill_wdata),
    .re    (acc_rd),
    .raddr (phys_row(base_r, rd_row)),
    .rdata (fill_q)
  );

  // cells past a row's written prefix are blank; out-of-range reads give zero
  always_comb begin
    rd_char = BLANK_CODE;
    if (rd_oor_r) begin
      rd_char = '0;
    end else if (rd_above_r) begin
      if (FW'(rd_col_r) < fill_q) rd_char = cell_q;
    end else if (rd_cur_r) begin
      if (rd_col_r < cur_col_r) rd_char = cell_q;
    end
  end

  // ---------------- next state of the registers ----------------
  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    base_nxt      = base_r;
    span_b_nxt    = span_b_r;
    span_e_nxt    = span_e_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (acc_wr || state_r == ST_READ) begin
      out_valid_nxt = 1'b1;
    end

    if (acc_wr) begin
      if (adv) begin
        cur_col_nxt = '0;
        if (scr) begin
          base_nxt = (base_r == RW'(ROWS - 1)) ? '0 : base_r + RW'(1);
        end else begin
          cur_row_nxt = cur_row_r + RW'(1);
        end
      end else begin
        cur_col_nxt = cur_col_r + CW'(1);
      end
      span_b_nxt = mb;
      span_e_nxt = me;
    end
    if (accept && in_end_of_span) begin
      span_b_nxt = '0;
      span_e_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      base_r      <= '0;
      span_b_r    <= '0;
      span_e_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      base_r      <= base_nxt;
      span_b_r    <= span_b_nxt;
      span_e_r    <= span_e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result fields, loaded on transfer; read data in the cycle after
  always_ff @(posedge clk) begin
    if (accept) begin
      o_db_r   <= acc_wr ? db : '0;
      o_de_r   <= acc_wr ? de : '0;
      o_sb_r   <= acc_wr ? mb : span_b_r;
      o_se_r   <= acc_wr ? me : span_e_r;
      o_scr_r  <= acc_wr && scr;
      o_char_r <= '0;
      o_col_r  <= acc_wr ? cur_col_nxt : cur_col_r;
      o_row_r  <= acc_wr ? cur_row_nxt : cur_row_r;
      rd_oor_r   <= !rd_in_range;
      rd_above_r <= rd_row < cur_row_r;
      rd_cur_r   <= rd_row == cur_row_r;
      rd_col_r   <= rd_col;
    end
    if (state_r == ST_READ) begin
      o_char_r <= rd_char;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dirty_begin    = PDIRTY_W'(o_db_r);
  assign out_dirty_end      = PDIRTY_W'(o_de_r);
  assign out_span_begin_out = PDIRTY_W'(o_sb_r);
  assign out_span_end_out   = PDIRTY_W'(o_se_r);
  assign out_scrolled       = o_scr_r;
  assign out_read_char      = o_char_r;
  assign out_cursor_col_out = PCOL_W'(o_col_r);
  assign out_cursor_row_out = PROW_W'(o_row_r);

  // ---------------- assertions ----------------
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && out_valid_r && out_stall))
    else $error("item taken while a stalled result waits");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_rd |=> (state_r == ST_READ) && !out_valid_r ##1 out_valid_r)
    else $error("read result not delivered after two cycles");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_scr_r) |-> (o_row_r == RW'(ROWS - 1)) && (o_col_r == '0))
    else $error("scroll left the cursor off the bottom row start");

  a_ring_base: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r != $past(base_r)) |-> $past(acc_wr && scr))
    else $error("top-row pointer moved without a scroll");

endmodule

// File: hw/rtl/ttcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/text_terminal_cell_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_test
// Self-checking testbench for the text terminal cell writer. A behavioral
// copy of the cell grid, cursor and span range predicts every result. Tests
// cover corner items, line wrap, scrolling and random traffic with idle and
// stall phases on both channels.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer_test
  import ttcw_pkg::*;
();

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [PDIRTY_W-1:0] dirty_begin;
    logic [PDIRTY_W-1:0] dirty_end;
    logic [PDIRTY_W-1:0] span_begin;
    logic [PDIRTY_W-1:0] span_end;
    logic                scrolled;
    logic [CHAR_W-1:0]   read_char;
    logic [PCOL_W-1:0]   cursor_col;
    logic [PROW_W-1:0]   cursor_row;
  } term_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_mode = MODE_WRITE;
  logic [CHAR_W-1:0]   in_char_code = '0;
  logic                in_end_of_span = 1'b0;
  logic [PROW_W-1:0]   in_read_row = '0;
  logic [PCOL_W-1:0]   in_read_col = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PDIRTY_W-1:0] out_dirty_begin;
  logic [PDIRTY_W-1:0] out_dirty_end;
  logic [PDIRTY_W-1:0] out_span_begin_out;
  logic [PDIRTY_W-1:0] out_span_end_out;
  logic                out_scrolled;
  logic [CHAR_W-1:0]   out_read_char;
  logic [PCOL_W-1:0]   out_cursor_col_out;
  logic [PROW_W-1:0]   out_cursor_row_out;

  // shadow terminal state
  logic [CHAR_W-1:0] shadow_grid [0:ROWS-1][0:COLUMNS-1];
  int shadow_col;
  int shadow_row;
  int shadow_span_lo;
  int shadow_span_hi;

  term_result_t results_due[$];
  int error_count = 0;
  int result_index = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  text_terminal_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_char_code(in_char_code),
    .in_end_of_span(in_end_of_span),
    .in_read_row(in_read_row),
    .in_read_col(in_read_col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dirty_begin(out_dirty_begin),
    .out_dirty_end(out_dirty_end),
    .out_span_begin_out(out_span_begin_out),
    .out_span_end_out(out_span_end_out),
    .out_scrolled(out_scrolled),
    .out_read_char(out_read_char),
    .out_cursor_col_out(out_cursor_col_out),
    .out_cursor_row_out(out_cursor_row_out)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic void clear_shadow();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        shadow_grid[r][c] = BLANK_CODE;
      end
    end
    shadow_col = 0;
    shadow_row = 0;
    shadow_span_lo = 0;
    shadow_span_hi = 0;
  endfunction

  function automatic void advance_shadow_line(output int lo, output int hi, output bit scr);
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          shadow_grid[r][c] = shadow_grid[r+1][c];
        end
      end
      for (int c = 0; c < COLUMNS; c++) begin
        shadow_grid[ROWS-1][c] = BLANK_CODE;
      end
      shadow_row = ROWS - 1;
      lo = 0;
      hi = ROWS;
      scr = 1'b1;
    end else begin
      lo = shadow_row - 1;
      hi = shadow_row + 1;
      scr = 1'b0;
    end
  endfunction

  function automatic term_result_t predict_terminal_result(
    input logic m, input logic [CHAR_W-1:0] ch, input logic eos,
    input logic [PROW_W-1:0] rr, input logic [PCOL_W-1:0] rc);
    term_result_t res;
    int lo;
    int hi;
    bit scr;
    res = '0;
    lo = 0;
    hi = 0;
    scr = 1'b0;
    if (m == MODE_WRITE) begin
      if (ch == NEWLINE_CODE) begin
        advance_shadow_line(lo, hi, scr);
      end else begin
        shadow_grid[shadow_row][shadow_col] = ch;
        shadow_col++;
        if (shadow_col >= COLUMNS) begin
          advance_shadow_line(lo, hi, scr);
        end else begin
          lo = shadow_row;
          hi = shadow_row + 1;
        end
      end
      // empty ranges leave the span alone
      if (lo != hi) begin
        if (shadow_span_lo == shadow_span_hi) begin
          shadow_span_lo = lo;
          shadow_span_hi = hi;
        end else begin
          if (lo < shadow_span_lo) shadow_span_lo = lo;
          if (hi > shadow_span_hi) shadow_span_hi = hi;
        end
      end
    end else if (rr < ROWS && rc < COLUMNS) begin
      res.read_char = shadow_grid[rr][rc];
    end
    res.dirty_begin = PDIRTY_W'(lo);
    res.dirty_end = PDIRTY_W'(hi);
    res.span_begin = PDIRTY_W'(shadow_span_lo);
    res.span_end = PDIRTY_W'(shadow_span_hi);
    res.scrolled = scr;
    res.cursor_col = PCOL_W'(shadow_col);
    res.cursor_row = PROW_W'(shadow_row);
    if (eos) begin
      shadow_span_lo = 0;
      shadow_span_hi = 0;
    end
    return res;
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_cell_item(input logic m, input logic [CHAR_W-1:0] ch,
                                input logic eos, input logic [PROW_W-1:0] rr,
                                input logic [PCOL_W-1:0] rc);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_char_code = ch;
    in_end_of_span = eos;
    in_read_row = rr;
    in_read_col = rc;
    do @(posedge clk); while (in_stall);
    results_due.push_back(predict_terminal_result(m, ch, eos, rr, rc));
    @(negedge clk);
  endtask

  task automatic write_char(input logic [CHAR_W-1:0] ch, input logic eos);
    send_cell_item(MODE_WRITE, ch, eos, PROW_W'($urandom_range(31)),
                   PCOL_W'($urandom_range(127)));
  endtask

  task automatic read_cell(input int rr, input int rc, input logic eos);
    send_cell_item(MODE_READ, CHAR_W'($urandom_range(255)), eos, PROW_W'(rr),
                   PCOL_W'(rc));
  endtask

  // printable text up to and through the wrap
  task automatic fill_to_line_end();
    int count;
    count = COLUMNS - shadow_col;
    for (int i = 0; i < count; i++) begin
      write_char(CHAR_W'($urandom_range(32, 126)), ($urandom_range(7) == 0));
    end
  endtask

  task automatic test_corner_items();
    read_cell(0, 0, 1'b0);
    read_cell(ROWS, 0, 1'b0);
    read_cell(0, COLUMNS, 1'b0);
    read_cell(31, 127, 1'b1);
    write_char(8'h00, 1'b0);
    write_char(8'hFF, 1'b1);
    write_char("A", 1'b0);
    read_cell(0, 0, 1'b0);
    read_cell(0, 1, 1'b1);
    read_cell(0, 2, 1'b0);
    write_char(NEWLINE_CODE, 1'b0);
    write_char(NEWLINE_CODE, 1'b1);
    write_char(8'h0B, 1'b0);
    write_char(8'h09, 1'b0);
    send_cell_item(MODE_WRITE, 8'h55, 1'b0, 5'h1F, 7'h7F);
    send_cell_item(MODE_WRITE, 8'hAA, 1'b1, 5'h00, 7'h00);
    read_cell(2, 0, 1'b0);
    read_cell(ROWS - 1, COLUMNS - 1, 1'b0);
    read_cell(5'h15, 7'h2A, 1'b1);
    read_cell(5'h0A, 7'h55, 1'b0);
  endtask

  task automatic test_line_wrap();
    int wrapped_row;
    wrapped_row = shadow_row;
    fill_to_line_end();
    read_cell(wrapped_row, COLUMNS - 1, 1'b0);
    read_cell(wrapped_row, 0, 1'b0);
    write_char("z", 1'b1);
  endtask

  task automatic test_scroll();
    while (shadow_row < ROWS - 1) begin
      write_char(NEWLINE_CODE, ($urandom_range(3) == 0));
    end
    write_char("q", 1'b0);
    write_char(NEWLINE_CODE, 1'b0);
    write_char("r", 1'b0);
    // wrap on the bottom row scrolls too
    fill_to_line_end();
    for (int r = ROWS - 3; r < ROWS; r++) begin
      read_cell(r, 0, 1'b0);
      read_cell(r, 1, 1'b0);
    end
    write_char("s", 1'b1);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int kind;
    int sent;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 2) begin
        sent += COLUMNS - shadow_col;
        fill_to_line_end();
      end else begin
        sent++;
        if (kind < 55) begin
          write_char(CHAR_W'($urandom_range(32, 126)), ($urandom_range(4) == 0));
        end else if (kind < 68) begin
          write_char(NEWLINE_CODE, ($urandom_range(4) == 0));
        end else if (kind < 76) begin
          write_char(CHAR_W'($urandom_range(255)), ($urandom_range(4) == 0));
        end else if (kind < 82) begin
          read_cell($urandom_range(31), $urandom_range(127), 1'($urandom_range(1)));
        end else if (kind < 91) begin
          read_cell(shadow_row, $urandom_range(COLUMNS - 1), ($urandom_range(4) == 0));
        end else begin
          read_cell($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1),
                    ($urandom_range(4) == 0));
        end
      end
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    stall_pct = 40;
    for (int i = 0; i < 12; i++) begin
      write_char(CHAR_W'($urandom_range(32, 126)), 1'b0);
    end
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    write_char(NEWLINE_CODE, 1'b1);
    read_cell(shadow_row, 0, 1'b0);
    test_random(20, 0, 40);
  endtask

  always @(negedge clk) begin
    out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_index, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    term_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_index));
      end else begin
        want = results_due.pop_front();
        compare_field("dirty_begin", int'(out_dirty_begin), int'(want.dirty_begin));
        compare_field("dirty_end", int'(out_dirty_end), int'(want.dirty_end));
        compare_field("span_begin", int'(out_span_begin_out), int'(want.span_begin));
        compare_field("span_end", int'(out_span_end_out), int'(want.span_end));
        compare_field("scrolled", int'(out_scrolled), int'(want.scrolled));
        compare_field("read_char", int'(out_read_char), int'(want.read_char));
        compare_field("cursor_col", int'(out_cursor_col_out), int'(want.cursor_col));
        compare_field("cursor_row", int'(out_cursor_row_out), int'(want.cursor_row));
      end
      result_index++;
    end
  end

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corner_items();
    test_line_wrap();
    test_scroll();
    test_random(120, 0, 0);
    test_random(120, 78, 0);
    test_random(120, 0, 78);
    test_random(120, 29, 29);
    test_drain_pause();
    test_random(100, 0, 0);

    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: text_terminal_cell_writer.f
hw/rtl/ttcw_pkg.sv
hw/rtl/ttcw_ram.sv
hw/rtl/text_terminal_cell_writer.sv
tb/text_terminal_cell_writer_test.sv
